// ===== hw/rtl/mtt_pkg.sv =====
// ---------------------------------------------------------------------------
// mtt_pkg - shared types for the multi timer table
// operation and reply codes, register indexes and the words passed along
// the row of timer cells
// ---------------------------------------------------------------------------
package mtt_pkg;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_KILL = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRE = 2'd0,
		KIND_SET  = 2'd1,
		KIND_KILL = 2'd2,
		KIND_READ = 2'd3
	} kind_t;

	typedef enum logic {
		REG_RUNNING = 1'b0,
		REG_TICK_MS = 1'b1
	} reg_t;

	localparam logic [9:0] TICK_MS_RESET = 10'd10;

	// command word travelling down the row
	typedef struct packed {
		logic        vld;
		op_t         op;
		logic [5:0]  id;
		logic [31:0] now;
		logic [31:0] ival;
		logic [31:0] pval;
		logic        rep;
		logic        claimed;
	} tok_t;

	// reply word from one cell
	typedef struct packed {
		logic        vld;
		logic [5:0]  slot;
		logic [31:0] param;
	} hit_t;

endpackage

// ===== hw/rtl/multi_timer_table_unit.sv =====
// ---------------------------------------------------------------------------
// multi_timer_table_unit - table of one-shot and periodic timers
// a row of TIMERS slot cells served by a command word that steps one cell
// per cycle; replies are collected and issued with a last marker
// ---------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Tick, set, kill and
// read that reach the table walk the row of TIMERS cells, one cell a cycle,
// so busy stays high until the word has left the last cell, and only then
// can a new command be taken. A tick while stopped gives no word; a set
// while stopped and a kill or read of a slot outside the table reply on the
// next cycle without touching the table. Each result word is shown for one
// cycle with valid high and cannot be held off; the final word of a command
// that walks the row appears in the first cycle with busy low.
module multi_timer_table_unit #(
	parameter int TIMERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [9:0]  wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [5:0]  timer_id,
	input  logic [31:0] interval,
	input  logic [31:0] param_value,
	input  logic        repeat_req,
	output logic        valid,
	output logic [1:0]  kind,
	output logic        ok,
	output logic [5:0]  slot,
	output logic [31:0] param_out,
	output logic        last
);

	mtt_pkg::tok_t     chain [TIMERS+1];
	mtt_pkg::hit_t     hits  [TIMERS];
	logic [TIMERS-1:0] hit_vld;
	mtt_pkg::hit_t     hit_any;

	logic              running_q;
	logic [9:0]        tick_ms_q;
	logic [31:0]       now_q;
	logic              busy_q;
	mtt_pkg::op_t      op_q;
	mtt_pkg::tok_t     tok_s0;

	logic              pend_vld_q;
	logic [5:0]        pend_slot_q;
	logic [31:0]       pend_param_q;

	logic              valid_q;
	mtt_pkg::kind_t    kind_q;
	logic              ok_q;
	logic [5:0]        slot_q;
	logic [31:0]       param_q;
	logic              last_q;

	mtt_pkg::op_t      op_in;
	logic              accept;
	logic              id_ok;
	logic              launch;
	logic              exit_w;
	logic [31:0]       now_nxt;

	logic              res_vld;
	mtt_pkg::kind_t    res_kind;
	logic              res_ok;
	logic [5:0]        res_slot;
	logic [31:0]       res_param;
	logic              res_last;

	assign op_in   = mtt_pkg::op_t'(opcode);
	assign accept  = start && !busy_q;
	assign id_ok   = ({1'b0, timer_id} < 7'(TIMERS));
	assign now_nxt = now_q + {22'd0, tick_ms_q};
	assign exit_w  = chain[TIMERS].vld;

	always_comb begin
		case (op_in)
			mtt_pkg::OP_TICK: launch = accept && running_q;
			mtt_pkg::OP_SET:  launch = accept && running_q;
			mtt_pkg::OP_KILL: launch = accept && id_ok;
			mtt_pkg::OP_READ: launch = accept && id_ok;
			default:          launch = 1'b0;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			tick_ms_q <= mtt_pkg::TICK_MS_RESET;
		end else if (wr_en) begin
			case (mtt_pkg::reg_t'(wr_index))
				mtt_pkg::REG_RUNNING: running_q <= wr_data[0];
				mtt_pkg::REG_TICK_MS: tick_ms_q <= wr_data;
				default:              running_q <= running_q;
			endcase
		end
	end

	// command launch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q  <= 32'd0;
			busy_q <= 1'b0;
			op_q   <= mtt_pkg::OP_TICK;
			tok_s0 <= '0;
		end else begin
			tok_s0.vld <= launch;
			if (launch) begin
				busy_q         <= 1'b1;
				op_q           <= op_in;
				tok_s0.op      <= op_in;
				tok_s0.id      <= timer_id;
				tok_s0.now     <= (op_in == mtt_pkg::OP_TICK) ? now_nxt : now_q;
				tok_s0.ival    <= (interval == 32'd0) ? 32'd1 : interval;
				tok_s0.pval    <= param_value;
				tok_s0.rep     <= repeat_req;
				tok_s0.claimed <= 1'b0;
				if (op_in == mtt_pkg::OP_TICK)
					now_q <= now_nxt;
			end else if (exit_w) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign chain[0] = tok_s0;

	for (genvar g = 0; g < TIMERS; g++) begin : g_cell
		mtt_cell #(
			.IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[g]),
			.tok_out(chain[g+1]),
			.hit    (hits[g])
		);
		assign hit_vld[g] = hits[g].vld;
	end

	// only the cell holding the word can answer
	always_comb begin
		hit_any = '0;
		for (int i = 0; i < TIMERS; i++)
			hit_any = hit_any | hits[i];
	end

	always_comb begin
		res_vld   = 1'b0;
		res_kind  = mtt_pkg::kind_t'(op_in);
		res_ok    = 1'b0;
		res_slot  = 6'd0;
		res_param = 32'd0;
		res_last  = 1'b1;
		if (accept) begin
			case (op_in)
				mtt_pkg::OP_SET: begin
					res_vld  = !running_q;
					res_kind = mtt_pkg::KIND_SET;
				end
				mtt_pkg::OP_KILL, mtt_pkg::OP_READ: begin
					res_vld  = !id_ok;
					res_slot = timer_id;
				end
				default: res_vld = 1'b0;
			endcase
		end else if (hit_any.vld) begin
			res_vld   = pend_vld_q;
			res_kind  = mtt_pkg::kind_t'(op_q);
			res_ok    = 1'b1;
			res_slot  = pend_slot_q;
			res_param = pend_param_q;
			res_last  = 1'b0;
		end else if (exit_w) begin
			res_kind = mtt_pkg::kind_t'(op_q);
			if (pend_vld_q) begin
				res_vld   = 1'b1;
				res_ok    = 1'b1;
				res_slot  = pend_slot_q;
				res_param = pend_param_q;
			end else begin
				// set found no free slot
				res_vld = (op_q == mtt_pkg::OP_SET);
			end
		end
	end

	// one word held back so the last marker is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (hit_any.vld) begin
			pend_vld_q <= 1'b1;
		end else if (exit_w) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_any.vld) begin
			pend_slot_q  <= hit_any.slot;
			pend_param_q <= hit_any.param;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			kind_q  <= res_kind;
			ok_q    <= res_ok;
			slot_q  <= res_slot;
			param_q <= res_param;
			last_q  <= res_last;
		end
	end

	assign busy      = busy_q;
	assign valid     = valid_q;
	assign kind      = kind_q;
	assign ok        = ok_q;
	assign slot      = slot_q;
	assign param_out = param_q;
	assign last      = last_q;

	a_hit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vld))
		else $error("more than one cell answering");

	a_hit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hit_any.vld |-> busy_q)
		else $error("cell answer while idle");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_w |-> busy_q && !launch)
		else $error("word left the row while idle");

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |-> busy_q)
		else $error("word without last marker and nothing in flight");

endmodule

// ===== hw/rtl/mtt_cell.sv =====
// ---------------------------------------------------------------------------
// mtt_cell - one timer slot
// holds the state of a single timer, serves the command word as it passes
// and registers the word before handing it to the next cell
// ---------------------------------------------------------------------------
module mtt_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mtt_pkg::tok_t tok_in,
	output mtt_pkg::tok_t tok_out,
	output mtt_pkg::hit_t hit
);

	logic          in_use_q;
	logic          periodic_q;
	logic [31:0]   period_q;
	logic [31:0]   lft_q;
	logic [31:0]   user_q;
	mtt_pkg::tok_t tok_q;
	mtt_pkg::tok_t tok_nxt;
	logic [31:0]   elapsed;
	logic          fire;
	logic          claim;
	logic          addr;

	assign elapsed = tok_in.now - lft_q;
	assign fire  = tok_in.vld && (tok_in.op == mtt_pkg::OP_TICK) && in_use_q
		&& (elapsed >= period_q);
	assign claim = tok_in.vld && (tok_in.op == mtt_pkg::OP_SET) && !tok_in.claimed
		&& !in_use_q;
	assign addr  = tok_in.vld
		&& ((tok_in.op == mtt_pkg::OP_KILL) || (tok_in.op == mtt_pkg::OP_READ))
		&& (tok_in.id == 6'(IDX));

	always_comb begin
		hit.vld   = fire || claim || addr;
		hit.slot  = (fire || claim || addr) ? 6'(IDX) : 6'd0;
		hit.param = addr ? user_q : 32'd0;
		tok_nxt         = tok_in;
		tok_nxt.claimed = tok_in.claimed || claim;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			user_q   <= 32'd0;
			tok_q    <= '0;
		end else begin
			tok_q <= tok_nxt;
			if (claim) begin
				in_use_q <= 1'b1;
				user_q   <= tok_in.pval;
			end else if (fire && !periodic_q) begin
				in_use_q <= 1'b0;
			end else if (addr && (tok_in.op == mtt_pkg::OP_KILL)) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			period_q   <= tok_in.ival;
			periodic_q <= tok_in.rep;
			lft_q      <= tok_in.now;
		end else if (fire) begin
			lft_q <= tok_in.now;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== tb/tb_multi_timer_table_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_timer_table_unit - self-checking testbench for the timer table
// drives tick, set, kill and read commands through the start/busy handshake
// under several register settings, keeps its own copy of the table to work
// out every reply and fire word, and checks the result words in order
// ---------------------------------------------------------------------------
module tb_multi_timer_table_unit;

	localparam int NSLOTS        = 16;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int SETTLE_CYCLES = 2 * NSLOTS + 8;

	typedef struct {
		mtt_pkg::kind_t kind;
		logic           ok;
		logic [5:0]     slot;
		logic [31:0]    param;
		logic           last;
	} reply_t;

	class timer_table_tracker;
		logic        used [NSLOTS];
		logic        repeating [NSLOTS];
		logic [31:0] period_ms [NSLOTS];
		logic [31:0] fired_at [NSLOTS];
		logic [31:0] user_word [NSLOTS];
		logic [31:0] now_ms;
		logic        running;
		logic [9:0]  step_ms;
		reply_t      replies [$];
		int          errors;

		function new();
			for (int i = 0; i < NSLOTS; i++) begin
				used[i] = 1'b0;
				repeating[i] = 1'b0;
				period_ms[i] = '0;
				fired_at[i] = '0;
				user_word[i] = '0;
			end
			now_ms = '0;
			running = 1'b0;
			step_ms = mtt_pkg::TICK_MS_RESET;
			errors = 0;
		endfunction

		function void write_reg(mtt_pkg::reg_t idx, logic [9:0] data);
			if (idx == mtt_pkg::REG_RUNNING)
				running = data[0];
			else
				step_ms = data;
		endfunction

		function void push_reply(mtt_pkg::kind_t k, logic o, logic [5:0] s,
				logic [31:0] p, logic l);
			reply_t r;
			r.kind = k;
			r.ok = o;
			r.slot = s;
			r.param = p;
			r.last = l;
			replies.insert(replies.size(), r);
		endfunction

		function void apply_command(mtt_pkg::op_t op, logic [5:0] id, logic [31:0] ival,
				logic [31:0] pval, logic rep);
			logic [NSLOTS-1:0] hits;
			int final_hit;
			int free_slot;
			hits = '0;
			final_hit = -1;
			free_slot = -1;
			case (op)
			mtt_pkg::OP_TICK: begin
				if (running) begin
					now_ms = now_ms + 32'(step_ms);
					for (int i = 0; i < NSLOTS; i++) begin
						if (used[i] && (now_ms - fired_at[i]) >= period_ms[i]) begin
							hits[i] = 1'b1;
							final_hit = i;
						end
					end
					for (int i = 0; i < NSLOTS; i++) begin
						if (hits[i]) begin
							push_reply(mtt_pkg::KIND_FIRE, 1'b1, 6'(i), '0,
								i == final_hit);
							if (!repeating[i])
								used[i] = 1'b0;
							fired_at[i] = now_ms;
						end
					end
				end
			end
			mtt_pkg::OP_SET: begin
				for (int i = NSLOTS - 1; i >= 0; i--)
					if (!used[i])
						free_slot = i;
				if (!running || free_slot < 0) begin
					push_reply(mtt_pkg::KIND_SET, 1'b0, '0, '0, 1'b1);
				end else begin
					used[free_slot] = 1'b1;
					period_ms[free_slot] = (ival == 0) ? 32'd1 : ival;
					user_word[free_slot] = pval;
					fired_at[free_slot] = now_ms;
					repeating[free_slot] = rep;
					push_reply(mtt_pkg::KIND_SET, 1'b1, 6'(free_slot), '0, 1'b1);
				end
			end
			default: begin
				if (id >= NSLOTS) begin
					push_reply(mtt_pkg::kind_t'(op), 1'b0, id, '0, 1'b1);
				end else begin
					if (op == mtt_pkg::OP_KILL)
						used[id] = 1'b0;
					push_reply(mtt_pkg::kind_t'(op), 1'b1, id, user_word[id], 1'b1);
				end
			end
			endcase
		endfunction

		function void check_reply(logic [1:0] k, logic o, logic [5:0] s,
				logic [31:0] p, logic l);
			reply_t want;
			if (replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: kind %0d ok %0b slot %0d param %h last %0b",
						k, o, s, p, l);
			end else begin
				want = replies.pop_front();
				if (k !== want.kind || o !== want.ok || s !== want.slot ||
						p !== want.param || l !== want.last) begin
					errors++;
					if (errors <= 10) begin
						$display("word mismatch: expected kind %0d ok %0b slot %0d param %h last %0b",
							want.kind, want.ok, want.slot, want.param, want.last);
						$display("  got kind %0d ok %0b slot %0d param %h last %0b",
							k, o, s, p, l);
					end
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [9:0]  wr_data;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [5:0]  timer_id;
	logic [31:0] interval;
	logic [31:0] param_value;
	logic        repeat_req;
	logic        valid;
	logic [1:0]  kind;
	logic        ok;
	logic [5:0]  slot;
	logic [31:0] param_out;
	logic        last;

	timer_table_tracker sb;
	bit idle_on;
	int cycles;

	multi_timer_table_unit #(
		.TIMERS(NSLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.timer_id(timer_id),
		.interval(interval),
		.param_value(param_value),
		.repeat_req(repeat_req),
		.valid(valid),
		.kind(kind),
		.ok(ok),
		.slot(slot),
		.param_out(param_out),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial cycles = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && valid)
			sb.check_reply(kind, ok, slot, param_out, last);
	end

	task automatic write_config(mtt_pkg::reg_t idx, logic [9:0] data);
		@(negedge clk);
		start = 1'b0;
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic send_command(mtt_pkg::op_t op, logic [5:0] id, logic [31:0] ival,
			logic [31:0] pval, logic rep);
		bit taken;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			opcode = op;
			timer_id = id;
			interval = ival;
			param_value = pval;
			repeat_req = rep;
			start = !(idle_on && $urandom_range(0, 99) < 25);
			@(posedge clk);
			if (start && !busy) begin
				taken = 1;
				sb.apply_command(op, id, ival, pval, rep);
			end
		end
	endtask

	// hold off until every word is back and the row has drained
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (sb.replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_command();
		int pick;
		mtt_pkg::op_t op;
		logic [5:0] id;
		logic [31:0] ival;
		logic [31:0] span;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			op = mtt_pkg::OP_TICK;
		else if (pick < 60)
			op = mtt_pkg::OP_SET;
		else if (pick < 80)
			op = mtt_pkg::OP_KILL;
		else
			op = mtt_pkg::OP_READ;
		if ($urandom_range(0, 9) == 0)
			id = 6'($urandom_range(NSLOTS, 63));
		else
			id = 6'($urandom_range(0, NSLOTS - 1));
		span = 32'(sb.step_ms) * 6 + 2;
		case ($urandom_range(0, 9))
		0: ival = $urandom();
		1: ival = '0;
		default: ival = $urandom_range(0, span);
		endcase
		send_command(op, id, ival, $urandom(), 1'($urandom()));
	endtask

	initial begin
		logic [9:0] step;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		wr_en = 1'b0;
		wr_index = mtt_pkg::REG_RUNNING;
		wr_data = '0;
		opcode = mtt_pkg::OP_TICK;
		timer_id = '0;
		interval = '0;
		param_value = '0;
		repeat_req = 1'b0;
		idle_on = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stopped after reset
		send_command(mtt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send_command(mtt_pkg::OP_SET, '0, 32'd5, 32'h1234_5678, 1'b1);
		send_command(mtt_pkg::OP_KILL, 6'(NSLOTS - 1), '0, '0, 1'b0);
		send_command(mtt_pkg::OP_READ, 6'd63, '0, '0, 1'b0);
		settle();

		write_config(mtt_pkg::REG_RUNNING, {9'($urandom()), 1'b1});
		write_config(mtt_pkg::REG_TICK_MS, 10'd1000);
		send_command(mtt_pkg::OP_SET, '0, '0, 32'hFFFF_FFFF, 1'b1);
		send_command(mtt_pkg::OP_SET, '0, 32'hFFFF_FFFF, '0, 1'b0);
		send_command(mtt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send_command(mtt_pkg::OP_KILL, 6'd0, '0, '0, 1'b0);
		send_command(mtt_pkg::OP_READ, 6'd0, '0, '0, 1'b0);
		send_command(mtt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		send_command(mtt_pkg::OP_KILL, 6'(NSLOTS), '0, '0, 1'b0);
		send_command(mtt_pkg::OP_KILL, 6'd1, '0, '0, 1'b0);
		// fill the table, overflow it, then fire every slot on one tick
		for (int i = 0; i <= NSLOTS; i++)
			send_command(mtt_pkg::OP_SET, '0, 32'd1, $urandom(), 1'(i));
		send_command(mtt_pkg::OP_TICK, '0, '0, '0, 1'b0);
		settle();

		for (int p = 0; p < 8; p++) begin
			case (p)
			0: step = 10'd1;
			1: step = 10'd1023;
			2: step = 10'd0;
			3: step = mtt_pkg::TICK_MS_RESET;
			default: step = 10'($urandom_range(1, 1000));
			endcase
			idle_on = (p != 4);
			write_config(mtt_pkg::REG_TICK_MS, step);
			write_config(mtt_pkg::REG_RUNNING, {9'($urandom()), 1'(p != 6)});
			repeat (50) random_command();
			settle();
		end

		if (sb.errors == 0 && sb.replies.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/mtt_pkg.sv
hw/rtl/mtt_cell.sv
hw/rtl/multi_timer_table_unit.sv
tb/tb_multi_timer_table_unit.sv
